>>> hw/rtl/interleave_match_counter_macros.svh
// Assertion macros for the interleave match counter.
// Empty bodies in synthesis builds.
`ifndef INTERLEAVE_MATCH_COUNTER_MACROS_SVH
`define INTERLEAVE_MATCH_COUNTER_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every rising clock edge out of reset
`define IMC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("imc: assertion failed");
// Condition must never be seen at a rising clock edge out of reset
`define IMC_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("imc: forbidden condition seen");
`else
`define IMC_ASSERT(lbl, clk, rst_n, prop)
`define IMC_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

>>> hw/rtl/imc_pkg.sv
`default_nettype none

package imc_pkg;

  // Field widths
  localparam int unsigned CmdW    = 2;
  localparam int unsigned PosW    = 14;
  localparam int unsigned ValW    = 16;
  localparam int unsigned SeqLenW = 13;
  localparam int unsigned WaysW   = 30;
  localparam int unsigned DataW   = 32;

  localparam int unsigned MaxLenDefault = 4096;

  localparam logic [WaysW-1:0] Modulus = 30'd998244353;

  // Command queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic [CmdW-1:0] {
    CMD_LOAD_A = 2'd0,
    CMD_LOAD_B = 2'd1,
    CMD_TARGET = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    OP_LOAD_A,
    OP_LOAD_B,
    OP_TARGET
  } op_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_UPDATE,
    BK_EMIT
  } back_state_e;

  // Classified item as queued for the back end
  typedef struct packed {
    op_e                kind;
    logic [PosW-1:0]    pos_m1;
    logic [ValW-1:0]    value;
    logic               first;
    logic               last;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Add two residues, result reduced once
  function automatic logic [WaysW-1:0] mod_add(input logic [WaysW-1:0] x,
                                                input logic [WaysW-1:0] y);
    logic [WaysW:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, Modulus}) begin
      s = s - {1'b0, Modulus};
    end
    return s[WaysW-1:0];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/imc_ram.sv
`default_nettype none

module imc_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 4096,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr0_i,
  input  wire logic [AddrW-1:0] raddr1_i,
  output logic      [Width-1:0] rdata0_o,
  output logic      [Width-1:0] rdata1_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Two registered read ports
  always_ff @(posedge clk_i) begin
    rdata0_o <= mem_q[raddr0_i];
    rdata1_o <= mem_q[raddr1_i];
  end

endmodule

`default_nettype wire

>>> hw/rtl/imc_front.sv
`default_nettype none

module imc_front #(
  parameter int unsigned MaxLen = imc_pkg::MaxLenDefault
) (
  input  wire logic                        in_valid_i,
  input  wire logic                        in_ready_i,
  input  wire logic [imc_pkg::CmdW-1:0]    cmd_i,
  input  wire logic [imc_pkg::PosW-1:0]    pos_i,
  input  wire logic [imc_pkg::ValW-1:0]    value_i,
  input  wire logic [imc_pkg::SeqLenW-1:0] seq_len_i,
  output logic      [imc_pkg::SeqLenW-1:0] seq_n_o,
  output logic                             push_o,
  output imc_pkg::op_t                     op_o
);

  import imc_pkg::*;

  localparam logic [16:0] MaxLenW = 17'(MaxLen);

  logic [PosW-1:0] two_n;
  logic            keep;

  // Clamp the length into its legal range
  always_comb begin
    if (seq_len_i == '0) begin
      seq_n_o = SeqLenW'(1);
    end else if ({4'b0, seq_len_i} > MaxLenW) begin
      seq_n_o = SeqLenW'(MaxLen);
    end else begin
      seq_n_o = seq_len_i;
    end
  end

  assign two_n = {seq_n_o, 1'b0};

  // Classify the item; drop what the back end has nothing to do with
  always_comb begin
    op_o.pos_m1 = pos_i - PosW'(1);
    op_o.value  = value_i;
    op_o.first  = (pos_i == PosW'(1));
    op_o.last   = (pos_i == two_n);
    op_o.kind   = OP_TARGET;
    keep        = 1'b0;
    case (cmd_e'(cmd_i))
      CMD_LOAD_A: begin
        op_o.kind = OP_LOAD_A;
        keep      = (pos_i != '0) && ({3'b0, pos_i} <= MaxLenW);
      end
      CMD_LOAD_B: begin
        op_o.kind = OP_LOAD_B;
        keep      = (pos_i != '0) && ({3'b0, pos_i} <= MaxLenW);
      end
      CMD_TARGET: begin
        op_o.kind = OP_TARGET;
        keep      = (pos_i != '0) && (pos_i <= two_n);
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push_o = in_valid_i && in_ready_i && keep;

endmodule

`default_nettype wire

>>> hw/rtl/imc_queue.sv
`default_nettype none

module imc_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire imc_pkg::op_t  op_i,
  input  wire logic          pop_i,
  output imc_pkg::op_t       head_o,
  output imc_pkg::q_status_t stat_o
);

  import imc_pkg::*;

  op_t                  entry_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] count_q, count_d;

  assign stat_o.full  = (count_q == QueueCntW'(QueueDepth));
  assign stat_o.empty = (count_q == '0);
  assign head_o       = entry_q[rd_ptr_q];

  // Advance pointers with wrap
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + QueuePtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + QueuePtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + QueueCntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - QueueCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store pushed entry
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/imc_back.sv
`default_nettype none

module imc_back #(
  parameter int unsigned MaxLen = imc_pkg::MaxLenDefault
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [imc_pkg::SeqLenW-1:0] seq_n_i,
  input  wire imc_pkg::op_t                head_i,
  input  wire imc_pkg::q_status_t          q_stat_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic      [imc_pkg::WaysW-1:0]   ways_o
);

  import imc_pkg::*;

  localparam int unsigned AddrW = (MaxLen > 1) ? $clog2(MaxLen) : 1;

  back_state_e state_q, state_d;

  // Path states
  logic [SeqLenW-1:0] ua_q, ua_d, ub_q, ub_d;
  logic [WaysW-1:0]   pa_q, pa_d, pb_q, pb_d;

  // Output register
  logic               out_valid_q, out_valid_d;
  logic [WaysW-1:0]   ways_q;
  logic               out_load;

  // Captured per-state operands for the update cycle
  logic [SeqLenW-1:0] u_q   [2];
  logic [WaysW-1:0]   c_q   [2];
  logic               aok_q [2];
  logic               bok_q [2];
  logic [ValW-1:0]    val_q;
  logic               last_q;

  logic [SeqLenW-1:0] pu    [2];
  logic [WaysW-1:0]   pc    [2];
  logic [PosW-1:0]    ubu   [2];
  logic               aok   [2];
  logic               bok   [2];

  logic [ValW-1:0]    rd_a  [2];
  logic [ValW-1:0]    rd_b  [2];
  logic               ma    [2];
  logic               mb    [2];
  logic [WaysW-1:0]   nac, nbc;

  logic               capture, we_a, we_b;

  // Previous state, or one empty path on the first target element
  always_comb begin
    pu[0] = head_i.first ? '0 : ua_q;
    pc[0] = head_i.first ? WaysW'(1) : pa_q;
    pu[1] = head_i.first ? '0 : ub_q;
    pc[1] = head_i.first ? '0 : pb_q;
  end

  // Liveness and source bounds of each state
  always_comb begin
    for (int s = 0; s < 2; s++) begin
      logic alive;
      logic le;
      le     = ({1'b0, pu[s]} <= head_i.pos_m1);
      ubu[s] = head_i.pos_m1 - {1'b0, pu[s]};
      alive  = (pc[s] != '0) && le && (pu[s] <= seq_n_i) && (ubu[s] <= {1'b0, seq_n_i});
      aok[s] = alive && (pu[s] < seq_n_i);
      bok[s] = alive && (ubu[s] < {1'b0, seq_n_i});
    end
  end

  imc_ram #(
    .Width (ValW),
    .Depth (MaxLen),
    .AddrW (AddrW)
  ) u_ram_a (
    .clk_i    (clk_i),
    .we_i     (we_a),
    .waddr_i  (AddrW'(head_i.pos_m1)),
    .wdata_i  (head_i.value),
    .raddr0_i (AddrW'(pu[0])),
    .raddr1_i (AddrW'(pu[1])),
    .rdata0_o (rd_a[0]),
    .rdata1_o (rd_a[1])
  );

  imc_ram #(
    .Width (ValW),
    .Depth (MaxLen),
    .AddrW (AddrW)
  ) u_ram_b (
    .clk_i    (clk_i),
    .we_i     (we_b),
    .waddr_i  (AddrW'(head_i.pos_m1)),
    .wdata_i  (head_i.value),
    .raddr0_i (AddrW'(ubu[0])),
    .raddr1_i (AddrW'(ubu[1])),
    .rdata0_o (rd_b[0]),
    .rdata1_o (rd_b[1])
  );

  // Match and combine contributions
  always_comb begin
    for (int s = 0; s < 2; s++) begin
      ma[s] = aok_q[s] && (rd_a[s] == val_q);
      mb[s] = bok_q[s] && (rd_b[s] == val_q);
    end
    nac = mod_add(ma[0] ? c_q[0] : '0, ma[1] ? c_q[1] : '0);
    nbc = mod_add(mb[0] ? c_q[0] : '0, mb[1] ? c_q[1] : '0);
  end

  // Sequencer: next state and control
  always_comb begin
    state_d     = state_q;
    pop_o       = 1'b0;
    capture     = 1'b0;
    we_a        = 1'b0;
    we_b        = 1'b0;
    out_load    = 1'b0;
    ua_d        = ua_q;
    pa_d        = pa_q;
    ub_d        = ub_q;
    pb_d        = pb_q;
    case (state_q)
      BK_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o = 1'b1;
          case (head_i.kind)
            OP_LOAD_A: we_a = 1'b1;
            OP_LOAD_B: we_b = 1'b1;
            OP_TARGET: begin
              capture = 1'b1;
              state_d = BK_UPDATE;
            end
            default: begin
              pop_o = 1'b1;
            end
          endcase
        end
      end
      BK_UPDATE: begin
        pa_d = nac;
        pb_d = nbc;
        if (nac == '0) begin
          ua_d = '0;
        end else if (ma[1]) begin
          ua_d = u_q[1] + SeqLenW'(1);
        end else begin
          ua_d = u_q[0] + SeqLenW'(1);
        end
        if (nbc == '0) begin
          ub_d = '0;
        end else if (mb[1]) begin
          ub_d = u_q[1];
        end else begin
          ub_d = u_q[0];
        end
        state_d = last_q ? BK_EMIT : BK_IDLE;
      end
      BK_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  // Output valid: set on load, drop on transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      ua_q        <= '0;
      pa_q        <= '0;
      ub_q        <= '0;
      pb_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ua_q        <= ua_d;
      pa_q        <= pa_d;
      ub_q        <= ub_d;
      pb_q        <= pb_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold operands for the update cycle
  always_ff @(posedge clk_i) begin
    if (capture) begin
      for (int s = 0; s < 2; s++) begin
        u_q[s]   <= pu[s];
        c_q[s]   <= pc[s];
        aok_q[s] <= aok[s];
        bok_q[s] <= bok[s];
      end
      val_q  <= head_i.value;
      last_q <= head_i.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      ways_q <= mod_add(pa_q, pb_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign ways_o      = ways_q;

endmodule

`default_nettype wire

>>> hw/rtl/interleave_match_counter.sv
`default_nettype none
`include "interleave_match_counter_macros.svh"

// Interleave match counter: load sources a and b (command 0 and 1, one
// element per transfer), write seq_len while idle, then stream target
// elements 1..2n (command 2); after element 2n one result gives the number
// of ways the target splits into an interleaving of a and b, modulo
// 998244353. Items pass through a two-entry queue, so the input accepts up
// to two further items while the back end works or a result waits. A load
// is written as it leaves the queue. A target element takes a registered
// read of both source memories, at addresses set by the previous element's
// used counts, then an update of both path states; the final element also
// loads the sum into the output register. Memories need no clearing after
// reset; an unloaded source entry reads as an arbitrary value.
module interleave_match_counter #(
  parameter int unsigned MAX_LEN = imc_pkg::MaxLenDefault
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // configuration: seq_len
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [imc_pkg::SeqLenW-1:0] cfg_data_i,
  // input stream
  input  wire logic                        s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  wire logic [imc_pkg::DataW-1:0]   s_axis_tdata_i,  // [13:0] position, [29:14] value
  input  wire logic [imc_pkg::CmdW-1:0]    s_axis_tuser_i,  // [1:0] command
  // result stream
  output logic                             m_axis_tvalid_o,
  input  wire logic                        m_axis_tready_i,
  output logic      [imc_pkg::DataW-1:0]   m_axis_tdata_o   // [29:0] ways
);

  import imc_pkg::*;

  logic [SeqLenW-1:0] seq_len_q;
  logic [SeqLenW-1:0] seq_n;
  logic               q_push;
  logic               q_pop;
  op_t                q_in;
  op_t                q_head;
  q_status_t          q_stat;
  logic [WaysW-1:0]   ways;

  // Length register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_len_q <= SeqLenW'(1);
    end else if (cfg_valid_i) begin
      seq_len_q <= cfg_data_i;
    end
  end

  assign s_axis_tready_o = !q_stat.full;

  imc_front #(
    .MaxLen (MAX_LEN)
  ) u_front (
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_i (s_axis_tready_o),
    .cmd_i      (s_axis_tuser_i),
    .pos_i      (s_axis_tdata_i[PosW-1:0]),
    .value_i    (s_axis_tdata_i[PosW+ValW-1:PosW]),
    .seq_len_i  (seq_len_q),
    .seq_n_o    (seq_n),
    .push_o     (q_push),
    .op_o       (q_in)
  );

  imc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .op_i   (q_in),
    .pop_i  (q_pop),
    .head_o (q_head),
    .stat_o (q_stat)
  );

  imc_back #(
    .MaxLen (MAX_LEN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seq_n_i     (seq_n),
    .head_i      (q_head),
    .q_stat_i    (q_stat),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .ways_o      (ways)
  );

  assign m_axis_tdata_o = {{(DataW - WaysW){1'b0}}, ways};

  // Checks
  `IMC_ASSERT_NEVER(a_queue_full_empty, clk_i, rst_ni, q_stat.full && q_stat.empty)
  `IMC_ASSERT(a_pop_nonempty, clk_i, rst_ni, q_pop |-> !q_stat.empty)
  `IMC_ASSERT(a_result_after_pop, clk_i, rst_ni, $rose(m_axis_tvalid_o) |-> $past(q_pop, 3))

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import imc_pkg::*;

  localparam int unsigned MaxLen      = MaxLenDefault;
  localparam int unsigned RandomItems = 1450;
  localparam int unsigned QuietFrom   = RandomItems * 85 / 100;
  localparam int unsigned IdleCycles  = 16;
  localparam int unsigned LongHold    = 300;
  localparam int unsigned TimeoutNs   = 20_000_000;

  // Command code left unused by the block
  localparam logic [CmdW-1:0] CMD_UNUSED = 2'd3;

  typedef enum {
    STREAM_CLEAN,
    STREAM_MUTATED,
    STREAM_BROKEN
  } stream_mode_e;

  // Path-count predictor and store of expected interleaving counts
  class WaysScoreboard;
    bit [ValW-1:0]    src_a [MaxLen];
    bit [ValW-1:0]    src_b [MaxLen];
    bit [SeqLenW-1:0] len_reg;
    bit [SeqLenW-1:0] used_end_a;
    bit [SeqLenW-1:0] used_end_b;
    bit [WaysW-1:0]   paths_end_a;
    bit [WaysW-1:0]   paths_end_b;
    bit [WaysW-1:0]   ways_q [$];
    int unsigned      failures;

    function new();
      len_reg  = 1;
      failures = 0;
    endfunction

    function void set_length(bit [SeqLenW-1:0] v);
      len_reg = v;
    endfunction

    function int unsigned pending();
      return ways_q.size();
    endfunction

    function bit [WaysW-1:0] add_residue(bit [WaysW-1:0] x, bit [WaysW-1:0] y);
      bit [WaysW:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, Modulus}) begin
        s = s - {1'b0, Modulus};
      end
      return s[WaysW-1:0];
    endfunction

    // Apply one accepted item: store a source load, or advance the two path states
    function void note_item(bit [CmdW-1:0] cmd, bit [PosW-1:0] pos, bit [ValW-1:0] val);
      int unsigned      n, p, u, ub, s;
      bit [SeqLenW-1:0] start_used [2];
      bit [WaysW-1:0]   start_paths [2];
      bit [SeqLenW-1:0] nu_a, nu_b;
      bit [WaysW-1:0]   np_a, np_b, c;
      n = len_reg;
      if (n < 1) n = 1;
      if (n > MaxLen) n = MaxLen;
      p = pos;
      if (cmd == CMD_LOAD_A || cmd == CMD_LOAD_B) begin
        if (p >= 1 && p <= MaxLen) begin
          if (cmd == CMD_LOAD_A) src_a[p-1] = val;
          else src_b[p-1] = val;
        end
        return;
      end
      if (cmd != CMD_TARGET) return;
      if (p < 1 || p > 2 * n) return;
      // Position one restarts from a single empty path
      if (p == 1) begin
        start_used[0] = 0; start_paths[0] = 1;
        start_used[1] = 0; start_paths[1] = 0;
      end else begin
        start_used[0] = used_end_a; start_paths[0] = paths_end_a;
        start_used[1] = used_end_b; start_paths[1] = paths_end_b;
      end
      nu_a = 0; nu_b = 0; np_a = 0; np_b = 0;
      for (s = 0; s < 2; s++) begin
        u = start_used[s];
        c = start_paths[s];
        if (c == 0) continue;
        if (u > p - 1 || u > n) continue;
        ub = p - 1 - u;
        if (ub > n) continue;
        if (u < n && src_a[u] == val) begin
          nu_a = SeqLenW'(u + 1);
          np_a = add_residue(np_a, c);
        end
        if (ub < n && src_b[ub] == val) begin
          nu_b = SeqLenW'(u);
          np_b = add_residue(np_b, c);
        end
      end
      // Drop the used count of a dead state
      if (np_a == 0) nu_a = 0;
      if (np_b == 0) nu_b = 0;
      used_end_a  = nu_a;
      paths_end_a = np_a;
      used_end_b  = nu_b;
      paths_end_b = np_b;
      if (p == 2 * n) ways_q.push_back(add_residue(np_a, np_b));
    endfunction

    function void check_ways(bit [WaysW-1:0] got);
      bit [WaysW-1:0] want;
      if (ways_q.size() == 0) begin
        $error("ways: unexpected result, expected none, actual %0d", got);
        failures++;
        return;
      end
      want = ways_q.pop_front();
      if (got !== want) begin
        $error("ways mismatch: expected %0d, actual %0d", want, got);
        failures++;
      end
    endfunction
  endclass

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               cfg_valid_i     = 1'b0;
  logic               cfg_ready_o;
  logic [SeqLenW-1:0] cfg_data_i      = '0;
  logic               s_axis_tvalid_i = 1'b0;
  logic               s_axis_tready_o;
  logic [DataW-1:0]   s_axis_tdata_i  = '0;
  logic [CmdW-1:0]    s_axis_tuser_i  = '0;
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i = 1'b0;
  logic [DataW-1:0]   m_axis_tdata_o;

  WaysScoreboard sb = new();

  bit          idle_on  = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned counted  = 0;

  // Loaded source contents and the value alphabet they were drawn from
  bit [ValW-1:0] seq_a [MaxLen];
  bit [ValW-1:0] seq_b [MaxLen];
  bit [ValW-1:0] alpha_off;
  bit [ValW-1:0] alpha_step;
  int unsigned   alpha_size;
  int unsigned   pool [2*MaxLen];

  interleave_match_counter u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic bit [ValW-1:0] alpha_value(int unsigned j);
    return ValW'(alpha_off + ValW'(j) * alpha_step);
  endfunction

  // Offer one item and hold it until the transfer
  task automatic send_item(input logic [CmdW-1:0] cmd, input logic [PosW-1:0] pos,
                           input logic [ValW-1:0] val);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {2'b00, val, pos};
    s_axis_tuser_i  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_item(cmd, pos, val);
  endtask

  // Hold the input until every result is in and the back end has settled
  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (IdleCycles) @(posedge clk_i);
  endtask

  task automatic write_length(input logic [SeqLenW-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_length(v);
  endtask

  // Load a and b with n distinct values each from a shared alphabet
  task automatic load_sources(input int unsigned n);
    int unsigned side, i, j, t;
    alpha_size = n + $urandom_range(0, n);
    alpha_off  = ValW'($urandom);
    alpha_step = ValW'($urandom) | 16'h0001;
    for (side = 0; side < 2; side++) begin
      for (i = 0; i < alpha_size; i++) pool[i] = i;
      for (i = 0; i < n; i++) begin
        j = $urandom_range(i, alpha_size - 1);
        t = pool[i]; pool[i] = pool[j]; pool[j] = t;
        if (side == 0) seq_a[i] = alpha_value(pool[i]);
        else seq_b[i] = alpha_value(pool[i]);
      end
    end
    for (i = 0; i < n; i++) begin
      send_item(CMD_LOAD_A, PosW'(i + 1), seq_a[i]);
      send_item(CMD_LOAD_B, PosW'(i + 1), seq_b[i]);
    end
    counted += 2 * n;
  endtask

  // Stream one target sequence: a true interleaving, one with a wrong
  // element, or positions out of order
  task automatic send_stream(input int unsigned n, input stream_mode_e mode);
    int unsigned   ia, ib, p, bad_pos, len;
    bit [ValW-1:0] v;
    bit [PosW-1:0] pos;
    if (mode == STREAM_BROKEN) begin
      len = $urandom_range(1, 2 * n + 2);
      repeat (len) begin
        pos = PosW'($urandom_range(0, 2 * n + 1));
        case ($urandom_range(0, 2))
          0:       v = seq_a[$urandom_range(0, n - 1)];
          1:       v = seq_b[$urandom_range(0, n - 1)];
          default: v = ValW'($urandom);
        endcase
        send_item(CMD_TARGET, pos, v);
        if (pos >= 1 && pos <= 2 * n) counted++;
      end
    end else begin
      ia = 0;
      ib = 0;
      bad_pos = (mode == STREAM_MUTATED) ? $urandom_range(1, 2 * n) : 0;
      for (p = 1; p <= 2 * n; p++) begin
        if (ib == n || (ia < n && $urandom_range(0, 1) == 1)) begin
          v = seq_a[ia];
          ia++;
        end else begin
          v = seq_b[ib];
          ib++;
        end
        if (p == bad_pos) v = alpha_value($urandom_range(0, alpha_size - 1));
        send_item(CMD_TARGET, PosW'(p), v);
      end
      counted += 2 * n;
    end
  endtask

  // Items the block must ignore
  task automatic send_noise(input int unsigned n);
    logic [CmdW-1:0] cmd;
    bit [PosW-1:0]   pos;
    case ($urandom_range(0, 2))
      0: begin
        cmd = CMD_UNUSED;
        pos = PosW'($urandom);
      end
      1: begin
        cmd = ($urandom_range(0, 1) == 1) ? CMD_LOAD_B : CMD_LOAD_A;
        pos = ($urandom_range(0, 1) == 1) ? '0 : PosW'($urandom_range(MaxLen + 1, 16383));
      end
      default: begin
        cmd = CMD_TARGET;
        pos = ($urandom_range(0, 1) == 1) ? '0 : PosW'($urandom_range(2 * n + 1, 16383));
      end
    endcase
    send_item(cmd, pos, ValW'($urandom));
  endtask

  // Result sink: random stalls, plus one long hold on request
  initial begin : result_sink
    int unsigned stall_left, hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) sb.check_ways(m_axis_tdata_o[WaysW-1:0]);
      if (hold_req) begin
        hold_left = LongHold;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) hold_left--;
      else if (stall_left > 0) stall_left--;
      else if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 4);
      m_axis_tready_i <= (hold_left == 0 && stall_left == 0);
    end
  end

  initial begin : stimulus
    int unsigned r, len_cfg, n;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, ignored items, stale state, restart
    send_item(CMD_LOAD_A, 14'd1, 16'h0000);
    send_item(CMD_LOAD_B, 14'd1, 16'hFFFF);
    send_item(CMD_UNUSED, 14'h3FFF, 16'hFFFF);
    send_item(CMD_LOAD_A, 14'd0, 16'h1234);
    send_item(CMD_LOAD_B, 14'h3FFF, 16'hFFFF);
    send_item(CMD_LOAD_A, 14'd4096, 16'hFFFF);
    send_item(CMD_LOAD_B, 14'd4097, 16'h0000);
    send_item(CMD_TARGET, 14'd2, 16'hFFFF);
    send_item(CMD_TARGET, 14'd0, 16'h0000);
    send_item(CMD_TARGET, 14'h3FFF, 16'hFFFF);
    send_item(CMD_TARGET, 14'd3, 16'h0000);
    send_item(CMD_TARGET, 14'd1, 16'h0000);
    send_item(CMD_TARGET, 14'd2, 16'hFFFF);
    send_item(CMD_TARGET, 14'd1, 16'hFFFF);
    send_item(CMD_TARGET, 14'd1, 16'h0000);
    send_item(CMD_TARGET, 14'd2, 16'hFFFF);
    send_item(CMD_TARGET, 14'd1, 16'h0000);
    send_item(CMD_TARGET, 14'd2, 16'h0000);
    // Zero length acts as one; equal sources give two ways
    wait_idle();
    write_length(13'd0);
    send_item(CMD_LOAD_A, 14'd1, 16'h5A5A);
    send_item(CMD_LOAD_B, 14'd1, 16'h5A5A);
    send_item(CMD_TARGET, 14'd1, 16'h5A5A);
    send_item(CMD_TARGET, 14'd2, 16'h5A5A);

    // Back-pressure: hold the sink while short streams pile up
    wait_idle();
    write_length(13'd2);
    load_sources(2);
    hold_req = 1'b1;
    repeat (20) send_stream(2, STREAM_CLEAN);

    // Largest length, first through an oversized register value; the top
    // target position still fits the field and closes a stream
    wait_idle();
    write_length(13'h1FFF);
    send_item(CMD_LOAD_A, 14'd4096, 16'h0F0F);
    send_item(CMD_LOAD_B, 14'd4096, 16'hF0F0);
    send_item(CMD_TARGET, 14'd8193, 16'h0000);
    send_item(CMD_TARGET, 14'd8192, 16'h0000);
    wait_idle();
    write_length(13'(MaxLen));
    send_item(CMD_TARGET, 14'd1, seq_a[0]);
    send_item(CMD_TARGET, 14'd8192, seq_b[0]);

    // Random phases, mostly short sequences
    counted = 0;
    while (counted < RandomItems) begin
      r = $urandom_range(0, 99);
      if (r < 10) len_cfg = 0;
      else if (r < 65) len_cfg = $urandom_range(1, 4);
      else if (r < 95) len_cfg = $urandom_range(5, 12);
      else len_cfg = $urandom_range(13, 40);
      n = (len_cfg == 0) ? 1 : len_cfg;
      wait_idle();
      write_length(SeqLenW'(len_cfg));
      load_sources(n);
      repeat ($urandom_range(2, 6)) begin
        if (counted >= QuietFrom) idle_on = 1'b0;
        r = $urandom_range(0, 99);
        if (r < 65) send_stream(n, STREAM_CLEAN);
        else if (r < 77) send_stream(n, STREAM_MUTATED);
        else if (r < 90) send_stream(n, STREAM_BROKEN);
        else if (r < 95) repeat ($urandom_range(1, 4)) send_noise(n);
        else load_sources(n);
      end
    end

    wait_idle();
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(TimeoutNs);
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/imc_pkg.sv
hw/rtl/imc_ram.sv
hw/rtl/imc_front.sv
hw/rtl/imc_queue.sv
hw/rtl/imc_back.sv
hw/rtl/interleave_match_counter.sv
tb/sv/tb.sv
